FILE: hdl/jsu_pkg.sv
package jsu_pkg;

    localparam int MAX_CAPACITY_DEF = 65536;
    localparam int CAP_W            = 17;
    localparam int LEN_W            = 17;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_SLASH     = 8'h2F;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_U         = 8'h75;

    localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0]  UTF8_CONT  = 8'h80;
    localparam logic [5:0]  UTF8_MASK  = 6'h3F;
    localparam logic [15:0] CP_ONE_MAX = 16'h0080;
    localparam logic [15:0] CP_TWO_MAX = 16'h0800;

    localparam logic KIND_DATA    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_ESCAPE = 2'd1,
        MODE_HEX    = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       is_last;
    } item_t;

    typedef struct packed {
        logic             kind;
        logic [7:0]       out_byte;
        logic             status;
        logic [LEN_W-1:0] out_count;
        logic             end_of_run;
    } result_t;

    // One decoded input: up to three data bytes and an optional summary
    typedef struct packed {
        logic [1:0]       data_cnt;
        logic [2:0][7:0]  data;
        logic             has_sum;
        logic             sum_status;
        logic [LEN_W-1:0] sum_len;
    } work_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } hex_t;

    typedef struct packed {
        logic       valid;
        logic [7:0] value;
    } esc_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t h;
        h.valid = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.valid = 1'b0;
        end
        return h;
    endfunction

    function automatic esc_t escape_map(input logic [7:0] c);
        esc_t e;
        e.valid = 1'b1;
        case (c)
            CHAR_QUOTE, CHAR_BACKSLASH, CHAR_SLASH: e.value = c;
            CHAR_B:  e.value = 8'h08;
            CHAR_F:  e.value = 8'h0C;
            CHAR_N:  e.value = 8'h0A;
            CHAR_R:  e.value = 8'h0D;
            CHAR_T:  e.value = 8'h09;
            default:
            begin
                e.valid = 1'b0;
                e.value = 8'h00;
            end
        endcase
        return e;
    endfunction

endpackage

FILE: hdl/jsu_front.sv
module jsu_front #(
    parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  jsu_pkg::item_t           item,
    input  logic [jsu_pkg::CAP_W-1:0] capacity,
    input  logic                     queue_full,
    output logic                     push,
    output jsu_pkg::work_t           push_data
);

    localparam int CNT_W = $clog2(MAX_CAPACITY + 1);
    localparam int W     = ((CNT_W > jsu_pkg::CAP_W) ? CNT_W : jsu_pkg::CAP_W) + 2;

    jsu_pkg::mode_t    mode_reg, mode_next, mode_a;
    logic [1:0]        hcnt_reg, hcnt_next, hcnt_a;
    logic [11:0]       acc_reg, acc_next, acc_a;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              err_reg, err_next;

    logic              accept;
    logic [W-1:0]      cap_w, cnt_w, cnt_a;
    logic [15:0]       cp;
    jsu_pkg::hex_t     hv;
    jsu_pkg::esc_t     ev;
    logic [1:0]        n_a;
    logic [2:0][7:0]   b_a;
    logic              err_a;

    assign item_ready = !queue_full;
    assign accept     = item_valid && item_ready;

    assign cap_w = (W'(capacity) > W'(MAX_CAPACITY)) ? W'(MAX_CAPACITY) : W'(capacity);
    assign cnt_w = W'(cnt_reg);
    assign hv    = jsu_pkg::hex_digit(item.in_byte);
    assign ev    = jsu_pkg::escape_map(item.in_byte);
    assign cp    = {acc_reg, hv.value};

    // Decode one byte against the current string state
    always_comb
    begin
        n_a    = 2'd0;
        b_a    = '0;
        mode_a = mode_reg;
        hcnt_a = hcnt_reg;
        acc_a  = acc_reg;
        err_a  = err_reg;
        if (!err_reg) begin
            case (mode_reg)
                jsu_pkg::MODE_ESCAPE:
                begin
                    mode_a = jsu_pkg::MODE_NORMAL;
                    if (ev.valid) begin
                        n_a    = 2'd1;
                        b_a[0] = ev.value;
                    end else if (item.in_byte == jsu_pkg::CHAR_U) begin
                        mode_a = jsu_pkg::MODE_HEX;
                        hcnt_a = 2'd0;
                        acc_a  = '0;
                    end else begin
                        err_a = 1'b1;
                    end
                end
                jsu_pkg::MODE_HEX:
                begin
                    if (!hv.valid) begin
                        err_a  = 1'b1;
                        mode_a = jsu_pkg::MODE_NORMAL;
                    end else if (hcnt_reg != 2'd3) begin
                        acc_a  = cp[11:0];
                        hcnt_a = hcnt_reg + 2'd1;
                    end else begin
                        acc_a  = cp[11:0];
                        mode_a = jsu_pkg::MODE_NORMAL;
                        hcnt_a = 2'd0;
                        if (cp < jsu_pkg::CP_ONE_MAX) begin
                            n_a    = 2'd1;
                            b_a[0] = cp[7:0];
                        end else if (cp < jsu_pkg::CP_TWO_MAX) begin
                            if (cnt_w + W'(2) > cap_w) begin
                                err_a = 1'b1;
                            end else begin
                                n_a    = 2'd2;
                                b_a[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]};
                                b_a[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0] & jsu_pkg::UTF8_MASK};
                            end
                        end else begin
                            if (cnt_w + W'(3) > cap_w) begin
                                err_a = 1'b1;
                            end else begin
                                n_a    = 2'd3;
                                b_a[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]};
                                b_a[1] = jsu_pkg::UTF8_CONT | {2'b00, cp[11:6]};
                                b_a[2] = jsu_pkg::UTF8_CONT | {2'b00, cp[5:0] & jsu_pkg::UTF8_MASK};
                            end
                        end
                    end
                end
                default:
                begin
                    mode_a = jsu_pkg::MODE_NORMAL;
                    if (cnt_w >= cap_w) begin
                        err_a = 1'b1;
                    end else if (item.in_byte == jsu_pkg::CHAR_BACKSLASH) begin
                        mode_a = jsu_pkg::MODE_ESCAPE;
                    end else begin
                        n_a    = 2'd1;
                        b_a[0] = item.in_byte;
                    end
                end
            endcase
        end
        // An escape left open by the final byte is a fault
        if (item.is_last && !err_a && mode_a != jsu_pkg::MODE_NORMAL) begin
            err_a = 1'b1;
        end
    end

    assign cnt_a = cnt_w + W'(n_a);

    // Next state
    always_comb
    begin
        mode_next = mode_reg;
        hcnt_next = hcnt_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;
        if (accept) begin
            if (item.is_last) begin
                mode_next = jsu_pkg::MODE_NORMAL;
                hcnt_next = 2'd0;
                acc_next  = '0;
                cnt_next  = '0;
                err_next  = 1'b0;
            end else begin
                mode_next = mode_a;
                hcnt_next = hcnt_a;
                acc_next  = acc_a;
                cnt_next  = CNT_W'(cnt_a);
                err_next  = err_a;
            end
        end
    end

    // Outputs toward the queue
    always_comb
    begin
        push                 = accept && (n_a != 2'd0 || item.is_last);
        push_data.data_cnt   = n_a;
        push_data.data       = b_a;
        push_data.has_sum    = item.is_last;
        push_data.sum_status = err_a;
        push_data.sum_len    = jsu_pkg::LEN_W'(cnt_a);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= jsu_pkg::MODE_NORMAL;
            hcnt_reg <= 2'd0;
            acc_reg  <= '0;
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end else begin
            mode_reg <= mode_next;
            hcnt_reg <= hcnt_next;
            acc_reg  <= acc_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
        end
    end

endmodule

FILE: hdl/jsu_queue.sv
module jsu_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  jsu_pkg::work_t push_data,
    output logic           full,
    input  logic           pop,
    output jsu_pkg::work_t head,
    output logic           empty
);

    jsu_pkg::work_t                entry_reg [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QPTR_W-1:0]    wr_reg, wr_next;
    logic [jsu_pkg::QPTR_W-1:0]    rd_reg, rd_next;
    logic [jsu_pkg::QCNT_W-1:0]    cnt_reg, cnt_next;

    assign full  = (cnt_reg == jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH));
    assign empty = (cnt_reg == '0);
    assign head  = entry_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? wr_reg + jsu_pkg::QPTR_W'(1) : wr_reg;
        rd_next  = pop ? rd_reg + jsu_pkg::QPTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + jsu_pkg::QCNT_W'(push) - jsu_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: hdl/jsu_back.sv
module jsu_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             empty,
    input  jsu_pkg::work_t   head,
    output logic             pop,
    output logic             result_valid,
    input  logic             result_ready,
    output jsu_pkg::result_t result
);

    logic [1:0]       idx_reg, idx_next;
    logic             valid_reg, valid_next;
    jsu_pkg::result_t res_reg, res_next;
    logic             load;
    logic             is_data;

    assign load    = !valid_reg || result_ready;
    assign is_data = (idx_reg < head.data_cnt);

    always_comb
    begin
        res_next   = res_reg;
        valid_next = valid_reg;
        idx_next   = idx_reg;
        pop        = 1'b0;
        if (load) begin
            valid_next = !empty;
            if (!empty) begin
                if (is_data) begin
                    res_next.kind           = jsu_pkg::KIND_DATA;
                    res_next.out_byte       = head.data[idx_reg];
                    res_next.status         = 1'b0;
                    res_next.out_count      = '0;
                    res_next.end_of_run     = (idx_reg == head.data_cnt - 2'd1) && !head.has_sum;
                end else begin
                    res_next.kind           = jsu_pkg::KIND_SUMMARY;
                    res_next.out_byte       = 8'h00;
                    res_next.status         = head.sum_status;
                    res_next.out_count      = head.sum_len;
                    res_next.end_of_run     = 1'b1;
                end
                // Retire the queue entry with its final result
                if (res_next.end_of_run) begin
                    pop      = 1'b1;
                    idx_next = 2'd0;
                end else begin
                    idx_next = idx_reg + 2'd1;
                end
            end
        end
    end

    assign result_valid = valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

FILE: hdl/json_string_unescape_utf8_unit.sv
// JSON string body unescaper with UTF-8 output.
// item channel (item_valid/item_ready/item): one raw byte of the string body
// per transfer, is_last set on the final byte.
// result channel (result_valid/result_ready/result): decoded data bytes,
// then one summary (kind 1) with status and decoded length after the last
// byte; end_of_run marks the last result caused by each input byte.
// cfg channel (cfg_valid/cfg_ready/cfg_capacity): output capacity, always
// ready; write it only while no string is in flight.
// A byte's results enter the queue when it transfers; the back end then
// loads each into the registered output, from which it is presented.
// Throughput: while result_ready is high, one input byte per cycle as long
// as each byte yields at most one result; the back end emits one result per
// cycle, so a u escape that expands to three bytes plus a summary holds it
// for four results; a four-entry queue from decoder to emitter absorbs them.
// Reset: string state clears, the queue empties, capacity returns to its
// maximum. A stalled result holds in the output register; the decoder keeps
// taking bytes until the queue fills, then drops item_ready.
module json_string_unescape_utf8_unit #(
    parameter int MAX_CAPACITY = jsu_pkg::MAX_CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  jsu_pkg::item_t            item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output jsu_pkg::result_t          result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [jsu_pkg::CAP_W-1:0] cfg_capacity
);

    logic [jsu_pkg::CAP_W-1:0] cap_reg, cap_next;
    logic                      queue_full, queue_empty, push, pop;
    jsu_pkg::work_t            push_data, head;

    assign cfg_ready = 1'b1;
    assign cap_next  = (cfg_valid && cfg_ready) ? cfg_capacity : cap_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cap_reg <= jsu_pkg::CAP_W'(MAX_CAPACITY);
        end else begin
            cap_reg <= cap_next;
        end
    end

    jsu_front #(
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .capacity   (cap_reg),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data)
    );

    jsu_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .head      (head),
        .empty     (queue_empty)
    );

    jsu_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (queue_empty),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: hdl/jsu_checker.sv
module jsu_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             result_valid,
    input logic             result_ready,
    input jsu_pkg::result_t result
);

    // A summary carries no byte and closes the run
    a_summary_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == jsu_pkg::KIND_SUMMARY |->
            result.out_byte == 8'h00 && result.end_of_run)
        else $error("summary result malformed");

    a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.kind == jsu_pkg::KIND_DATA |->
            !result.status && result.out_count == '0)
        else $error("data result carries summary fields");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid)
        else $error("result dropped while stalled");

    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> $stable(result))
        else $error("result changed while stalled");

endmodule

bind json_string_unescape_utf8_unit jsu_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);

FILE: test/testbench.sv
module testbench;

    localparam int MAX_CAP      = jsu_pkg::MAX_CAPACITY_DEF;
    localparam int CAP_W        = jsu_pkg::CAP_W;
    localparam int LEN_W        = jsu_pkg::LEN_W;
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 100;
    localparam int PHASE_ITEMS  = 25;
    localparam int N_PHASES     = 10;
    localparam int HOLD_PHASE   = 2;
    localparam int RAND_PHASE   = 7;
    localparam int USE_PRED     = -1;

    // Directed row: n_fix < 0 takes the predicted results, else the typed ones
    typedef struct {
        jsu_pkg::item_t   din;
        int               n_fix;
        jsu_pkg::result_t fix0;
        jsu_pkg::result_t fix1;
    } dir_row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 item_valid   = 1'b0;
    logic                 item_ready;
    jsu_pkg::item_t       item         = '0;
    logic                 result_valid;
    logic                 result_ready = 1'b0;
    jsu_pkg::result_t     result;
    logic                 cfg_valid    = 1'b0;
    logic                 cfg_ready;
    logic [CAP_W-1:0]     cfg_capacity = '0;

    // Decoder state mirrored by the predictor
    jsu_pkg::mode_t       dec_mode     = jsu_pkg::MODE_NORMAL;
    logic [1:0]           dec_hex_cnt  = '0;
    logic [15:0]          dec_cp       = '0;
    logic [LEN_W-1:0]     dec_emitted  = '0;
    logic                 dec_err      = 1'b0;
    logic [CAP_W-1:0]     cap_setting  = CAP_W'(MAX_CAP);

    jsu_pkg::result_t     decoded_q [$];
    jsu_pkg::result_t     seen_q [$];
    jsu_pkg::result_t     step_q [$];
    logic [7:0]           str_q [$];
    dir_row_t             dir_tab [$];

    jsu_pkg::result_t     got_r;
    jsu_pkg::result_t     want_r;
    int                   err_cnt      = 0;
    int                   idle_cycles  = 0;
    int                   stall_left   = 0;
    bit                   pace         = 1'b1;
    bit                   hold_req     = 1'b0;

    json_string_unescape_utf8_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_capacity (cfg_capacity)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic jsu_pkg::result_t data_res(input logic [7:0] b, input logic eor);
        jsu_pkg::result_t r;
        r = '0;
        r.kind = jsu_pkg::KIND_DATA;
        r.out_byte = b;
        r.end_of_run = eor;
        return r;
    endfunction

    function automatic jsu_pkg::result_t summary_res(input logic st,
                                                     input logic [LEN_W-1:0] len);
        jsu_pkg::result_t r;
        r = '0;
        r.kind = jsu_pkg::KIND_SUMMARY;
        r.status = st;
        r.out_count = len;
        r.end_of_run = 1'b1;
        return r;
    endfunction

    function automatic dir_row_t row(input logic [7:0] b, input logic last, input int n,
                                     input jsu_pkg::result_t r0 = '0,
                                     input jsu_pkg::result_t r1 = '0);
        dir_row_t d;
        d.din.in_byte = b;
        d.din.is_last = last;
        d.n_fix = n;
        d.fix0 = r0;
        d.fix1 = r1;
        return d;
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        step_q.push_back(data_res(b, 1'b0));
        dec_emitted++;
    endfunction

    // Work out the results caused by one input byte and advance the decoder
    function automatic void unescape_byte(input jsu_pkg::item_t it);
        logic [CAP_W-1:0] cap;
        logic [7:0]       c;
        logic [3:0]       nib;
        logic             is_digit;
        logic             is_alpha;
        logic [15:0]      cp;
        c = it.in_byte;
        cap = (cap_setting < CAP_W'(MAX_CAP)) ? cap_setting : CAP_W'(MAX_CAP);
        step_q.delete();
        if (!dec_err) begin
            case (dec_mode)
                jsu_pkg::MODE_ESCAPE:
                begin
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    case (c)
                        jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH,
                        jsu_pkg::CHAR_SLASH: put_byte(c);
                        jsu_pkg::CHAR_B: put_byte(8'h08);
                        jsu_pkg::CHAR_F: put_byte(8'h0C);
                        jsu_pkg::CHAR_N: put_byte(8'h0A);
                        jsu_pkg::CHAR_R: put_byte(8'h0D);
                        jsu_pkg::CHAR_T: put_byte(8'h09);
                        jsu_pkg::CHAR_U:
                        begin
                            dec_mode = jsu_pkg::MODE_HEX;
                            dec_hex_cnt = '0;
                            dec_cp = '0;
                        end
                        default: dec_err = 1'b1;
                    endcase
                end
                jsu_pkg::MODE_HEX:
                begin
                    is_digit = (c >= 8'h30 && c <= 8'h39);
                    is_alpha = ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h66);
                    nib = c[3:0] + (is_alpha ? 4'd9 : 4'd0);
                    if (!is_digit && !is_alpha) begin
                        dec_err = 1'b1;
                        dec_mode = jsu_pkg::MODE_NORMAL;
                    end else begin
                        dec_cp = {dec_cp[11:0], nib};
                        if (dec_hex_cnt < 2'd3) begin
                            dec_hex_cnt++;
                        end else begin
                            cp = dec_cp;
                            dec_mode = jsu_pkg::MODE_NORMAL;
                            dec_hex_cnt = '0;
                            if (cp < jsu_pkg::CP_ONE_MAX) begin
                                put_byte(cp[7:0]);
                            end else if (cp < jsu_pkg::CP_TWO_MAX) begin
                                if (int'(dec_emitted) + 2 > int'(cap)) begin
                                    dec_err = 1'b1;
                                end else begin
                                    put_byte(jsu_pkg::UTF8_LEAD2 | 8'(cp[10:6]));
                                    put_byte(jsu_pkg::UTF8_CONT | 8'(cp[5:0]));
                                end
                            end else begin
                                if (int'(dec_emitted) + 3 > int'(cap)) begin
                                    dec_err = 1'b1;
                                end else begin
                                    put_byte(jsu_pkg::UTF8_LEAD3 | 8'(cp[15:12]));
                                    put_byte(jsu_pkg::UTF8_CONT | 8'(cp[11:6]));
                                    put_byte(jsu_pkg::UTF8_CONT | 8'(cp[5:0]));
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    // capacity is checked when a new element starts
                    dec_mode = jsu_pkg::MODE_NORMAL;
                    if (dec_emitted >= cap) begin
                        dec_err = 1'b1;
                    end else if (c == jsu_pkg::CHAR_BACKSLASH) begin
                        dec_mode = jsu_pkg::MODE_ESCAPE;
                    end else begin
                        put_byte(c);
                    end
                end
            endcase
        end
        if (it.is_last) begin
            // an escape left open by the final byte is an error
            if (!dec_err && dec_mode != jsu_pkg::MODE_NORMAL) begin
                dec_err = 1'b1;
            end
            step_q.push_back(summary_res(dec_err, dec_emitted));
            dec_mode = jsu_pkg::MODE_NORMAL;
            dec_hex_cnt = '0;
            dec_cp = '0;
            dec_emitted = '0;
            dec_err = 1'b0;
        end
        if (step_q.size() > 0) begin
            step_q[step_q.size() - 1].end_of_run = 1'b1;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (!pace) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'h30 + 8'(v);
        end
        return (($urandom_range(0, 1) == 1) ? 8'h41 : 8'h61) + 8'(v - 4'd10);
    endfunction

    function automatic logic [7:0] bad_hex_char();
        case ($urandom_range(0, 6))
            0: return 8'h2F;
            1: return 8'h3A;
            2: return 8'h40;
            3: return 8'h47;
            4: return 8'h60;
            5: return 8'h67;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed strings with random content, some broken escapes
    function automatic void build_string();
        int          n_elem;
        int          sel;
        int          k;
        logic [15:0] cp;
        logic [7:0]  simple_esc [8];
        simple_esc = '{jsu_pkg::CHAR_QUOTE, jsu_pkg::CHAR_BACKSLASH, jsu_pkg::CHAR_SLASH,
                       jsu_pkg::CHAR_B, jsu_pkg::CHAR_F, jsu_pkg::CHAR_N,
                       jsu_pkg::CHAR_R, jsu_pkg::CHAR_T};
        str_q.delete();
        n_elem = $urandom_range(1, 8);
        for (int e = 0; e < n_elem; e++) begin
            sel = $urandom_range(0, 99);
            if (sel < 50) begin
                str_q.push_back(8'($urandom_range(0, 255)));
            end else if (sel < 70) begin
                str_q.push_back(jsu_pkg::CHAR_BACKSLASH);
                str_q.push_back(simple_esc[$urandom_range(0, 7)]);
            end else if (sel < 90) begin
                case ($urandom_range(0, 8))
                    0: cp = 16'h0000;
                    1: cp = 16'h007F;
                    2: cp = 16'h0080;
                    3: cp = 16'h07FF;
                    4: cp = 16'h0800;
                    5: cp = 16'hFFFF;
                    6: cp = 16'($urandom_range(0, 16'h7F));
                    7: cp = 16'($urandom_range(16'h80, 16'h7FF));
                    default: cp = 16'($urandom_range(16'h800, 16'hFFFF));
                endcase
                str_q.push_back(jsu_pkg::CHAR_BACKSLASH);
                str_q.push_back(jsu_pkg::CHAR_U);
                str_q.push_back(hex_char(cp[15:12]));
                str_q.push_back(hex_char(cp[11:8]));
                str_q.push_back(hex_char(cp[7:4]));
                str_q.push_back(hex_char(cp[3:0]));
            end else if (sel < 95) begin
                str_q.push_back(jsu_pkg::CHAR_BACKSLASH);
                str_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                k = $urandom_range(0, 3);
                str_q.push_back(jsu_pkg::CHAR_BACKSLASH);
                str_q.push_back(jsu_pkg::CHAR_U);
                repeat (k) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
                str_q.push_back(bad_hex_char());
            end
        end
        // cut the string off inside an escape now and then
        if ($urandom_range(0, 19) == 0) begin
            str_q.push_back(jsu_pkg::CHAR_BACKSLASH);
            if ($urandom_range(0, 1) == 1) begin
                str_q.push_back(jsu_pkg::CHAR_U);
                k = $urandom_range(0, 3);
                repeat (k) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
            end
        end
    endfunction

    task automatic push_item(input jsu_pkg::item_t it, input int n_fix,
                             input jsu_pkg::result_t fix0, input jsu_pkg::result_t fix1);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (!item_ready);
        unescape_byte(it);
        if (n_fix < 0) begin
            foreach (step_q[i]) decoded_q.push_back(step_q[i]);
        end else begin
            if (n_fix > 0) decoded_q.push_back(fix0);
            if (n_fix > 1) decoded_q.push_back(fix1);
        end
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_capacity <= v;
        do @(posedge clk); while (!cfg_ready);
        cap_setting = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk) begin
        if (rst_n && result_valid && result_ready) begin
            seen_q.push_back(result);
        end
    end

    // Check at the falling edge, once every prediction of the rising edge is in
    always @(negedge clk) begin
        while (seen_q.size() > 0) begin
            got_r = seen_q.pop_front();
            if (decoded_q.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10) begin
                    $display("unexpected result: kind=%0d byte=%02h status=%0d len=%0d eor=%0d",
                             got_r.kind, got_r.out_byte, got_r.status,
                             got_r.out_count, got_r.end_of_run);
                end
            end else begin
                want_r = decoded_q.pop_front();
                if (got_r.kind !== want_r.kind || got_r.out_byte !== want_r.out_byte ||
                    got_r.status !== want_r.status ||
                    got_r.out_count !== want_r.out_count ||
                    got_r.end_of_run !== want_r.end_of_run) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $display("mismatch: exp kind=%0d byte=%02h status=%0d len=%0d eor=%0d",
                                 want_r.kind, want_r.out_byte, want_r.status,
                                 want_r.out_count, want_r.end_of_run);
                        $display("          got kind=%0d byte=%02h status=%0d len=%0d eor=%0d",
                                 got_r.kind, got_r.out_byte, got_r.status,
                                 got_r.out_count, got_r.end_of_run);
                    end
                end
            end
        end
        if (hold_req) begin
            hold_req = 1'b0;
            stall_left = HOLD_CYCLES;
        end
        if (stall_left > 0) begin
            stall_left--;
            result_ready <= 1'b0;
        end else begin
            stall_left = ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            result_ready <= (stall_left == 0);
        end
    end

    always @(posedge clk) begin
        if ((item_valid && item_ready) || (result_valid && result_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int             phase_items;
        int             cap_plan [N_PHASES];
        jsu_pkg::item_t it;
        cap_plan = '{3, 1, MAX_CAP, 0, 6, 131071, 2, 0, 10, MAX_CAP - 1};

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed strings at the reset capacity
        dir_tab.push_back(row(8'h00, 1'b0, 1, data_res(8'h00, 1'b1)));
        dir_tab.push_back(row(8'hFF, 1'b0, 1, data_res(8'hFF, 1'b1)));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b0, 0));
        dir_tab.push_back(row(jsu_pkg::CHAR_U, 1'b0, 0));
        dir_tab.push_back(row(8'h46, 1'b0, 0));
        dir_tab.push_back(row(8'h66, 1'b0, 0));
        dir_tab.push_back(row(8'h46, 1'b0, 0));
        dir_tab.push_back(row(8'h66, 1'b0, USE_PRED));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b0, 0));
        dir_tab.push_back(row(jsu_pkg::CHAR_U, 1'b0, 0));
        dir_tab.push_back(row(8'h30, 1'b0, 0));
        dir_tab.push_back(row(8'h37, 1'b0, 0));
        dir_tab.push_back(row(8'h46, 1'b0, 0));
        dir_tab.push_back(row(8'h66, 1'b1, USE_PRED));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b0, 0));
        dir_tab.push_back(row(8'h71, 1'b0, 0));
        dir_tab.push_back(row(8'h78, 1'b1, 1, summary_res(1'b1, '0)));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b0, 0));
        dir_tab.push_back(row(jsu_pkg::CHAR_U, 1'b0, 0));
        dir_tab.push_back(row(8'h67, 1'b1, 1, summary_res(1'b1, '0)));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b1, 1, summary_res(1'b1, '0)));
        dir_tab.push_back(row(jsu_pkg::CHAR_BACKSLASH, 1'b0, 0));
        dir_tab.push_back(row(jsu_pkg::CHAR_T, 1'b0, 1, data_res(8'h09, 1'b1)));
        dir_tab.push_back(row(jsu_pkg::CHAR_QUOTE, 1'b1, 2, data_res(8'h22, 1'b0),
                              summary_res(1'b0, LEN_W'(2))));
        foreach (dir_tab[i]) begin
            push_item(dir_tab[i].din, dir_tab[i].n_fix, dir_tab[i].fix0, dir_tab[i].fix1);
        end

        for (int p = 0; p < N_PHASES; p++) begin
            @(negedge clk);
            item_valid <= 1'b0;
            // drain, then let bytes with no result clear the pipe
            while (decoded_q.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            if (p == RAND_PHASE) begin
                write_capacity(CAP_W'($urandom_range(4, 24)));
            end else begin
                write_capacity(CAP_W'(cap_plan[p]));
            end
            pace = (p != HOLD_PHASE && p != 5);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_string();
                foreach (str_q[i]) begin
                    it.in_byte = str_q[i];
                    it.is_last = (i == str_q.size() - 1);
                    push_item(it, USE_PRED, '0, '0);
                end
                phase_items += str_q.size();
            end
        end

        @(negedge clk);
        item_valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        @(posedge clk);
        if (err_cnt == 0 && decoded_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
